// File: hw/rtl/rule30_ca_random_number_unit_assert.svh
// Assertion macros shared by the rule 30 unit.
// Every user has ports named clk and rst_n.
`ifndef RULE30_CA_RANDOM_NUMBER_UNIT_ASSERT_SVH
`define RULE30_CA_RANDOM_NUMBER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RC30_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RC30_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rc30_pkg.sv
`default_nettype none

package rc30_pkg;

    localparam int MAX_CELLS_DEF = 128;
    localparam int SEED_W        = 64;
    localparam int NUM_W         = 64;
    localparam int ROW_W         = 7;   // start row, generation index, half width
    localparam int CNT_W         = 8;   // ring length, up to 128
    localparam int POS_W         = 6;   // bit position in the result

    localparam logic [ROW_W-1:0] HALF_WIDTH_RST = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } ring_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/rc30_if.sv
`default_nettype none

interface rc30_req_if;
    logic                                valid;
    logic                                ready;
    logic signed [rc30_pkg::SEED_W-1:0]  seed;
    logic        [rc30_pkg::ROW_W-1:0]   start_row;

    modport source (output valid, output seed, output start_row, input ready);
    modport sink   (input valid, input seed, input start_row, output ready);
endinterface

interface rc30_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rc30_pkg::NUM_W-1:0]    number;
    logic                          bad_start;

    modport source (output valid, output number, output bad_start, input ready);
    modport sink   (input valid, input number, input bad_start, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rc30_ring.sv
`default_nettype none

// Cell ring with the rule 30 generation unit: one generation per step.
module rc30_ring #(
    parameter int MAX_CELLS = rc30_pkg::MAX_CELLS_DEF
) (
    input  wire logic                              clk,
    input  wire rc30_pkg::ring_ctl_t               ctl,
    input  wire logic signed [rc30_pkg::SEED_W-1:0] seed,
    input  wire logic [rc30_pkg::CNT_W-1:0]        n,
    input  wire logic [rc30_pkg::ROW_W-1:0]        w,
    output logic                                   center
);

    localparam int IW = $clog2(MAX_CELLS);

    logic [MAX_CELLS-1:0]     ring_reg;
    logic [MAX_CELLS-1:0]     ring_next;
    logic [MAX_CELLS-1:0]     load_row;
    logic [MAX_CELLS-1:0]     step_row;
    logic [rc30_pkg::CNT_W-1:0] n_m1;
    logic                     last_cell;

    assign n_m1      = n - rc30_pkg::CNT_W'(1);
    assign last_cell = ring_reg[n_m1[IW-1:0]];
    assign center    = ring_reg[w[IW-1:0]];

    always_comb
    begin
        for (int i = 0; i < MAX_CELLS; i++)
        begin
            // cells past the seed's top bit take its sign bit
            load_row[i] = (rc30_pkg::CNT_W'(i) < n) ?
                          seed[(i < rc30_pkg::SEED_W) ? i : rc30_pkg::SEED_W - 1] : 1'b0;
        end
    end

    always_comb
    begin
        logic l_bit;
        logic r_bit;
        for (int i = 0; i < MAX_CELLS; i++)
        begin
            l_bit = (i == 0) ? last_cell : ring_reg[(i == 0) ? 0 : i - 1];
            if (rc30_pkg::CNT_W'(i) == n_m1)
                r_bit = ring_reg[0];
            else
                r_bit = ring_reg[(i == MAX_CELLS - 1) ? 0 : i + 1];
            step_row[i] = l_bit ^ (ring_reg[i] | r_bit);
        end
    end

    always_comb
    begin
        ring_next = ring_reg;
        if (ctl.load)
            ring_next = load_row;
        else if (ctl.step)
            ring_next = step_row;
    end

    always_ff @(posedge clk)
    begin
        ring_reg <= ring_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/rc30_ctrl.sv
`default_nettype none
`include "rule30_ca_random_number_unit_assert.svh"

// Sequencer: runs the generations and builds the result from the centre cells.
module rc30_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [rc30_pkg::ROW_W-1:0]    start_row,
    input  wire logic [rc30_pkg::ROW_W-1:0]    w,
    input  wire logic [rc30_pkg::CNT_W-1:0]    n,
    input  wire logic                          center,
    input  wire logic                          out_free,
    output rc30_pkg::ring_ctl_t                ctl,
    output logic                               idle,
    output logic                               fire,
    output logic [rc30_pkg::NUM_W-1:0]         number,
    output logic                               bad
);

    rc30_pkg::state_t                state_reg, state_next;
    logic [rc30_pkg::ROW_W-1:0]      gen_reg, gen_next;
    logic [rc30_pkg::ROW_W-1:0]      start_reg, start_next;
    logic [rc30_pkg::NUM_W-1:0]      num_reg, num_next;
    logic                            bad_reg, bad_next;

    logic [rc30_pkg::CNT_W-1:0]      gen_x;
    logic [rc30_pkg::CNT_W-1:0]      start_x;
    logic [rc30_pkg::CNT_W-1:0]      w_x;
    logic [rc30_pkg::CNT_W-1:0]      off;
    logic [rc30_pkg::POS_W-1:0]      pos;
    logic                            in_win;
    logic                            last_gen;

    assign gen_x    = rc30_pkg::CNT_W'(gen_reg);
    assign start_x  = rc30_pkg::CNT_W'(start_reg);
    assign w_x      = rc30_pkg::CNT_W'(w);
    // distance of this generation from the start row, around the ring
    assign off      = (gen_x >= start_x) ? (gen_x - start_x) : (gen_x + n - start_x);
    assign in_win   = off < w_x;
    assign pos      = rc30_pkg::POS_W'(w_x - rc30_pkg::CNT_W'(1) - off);
    assign last_gen = gen_x == (n - rc30_pkg::CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rc30_pkg::ST_IDLE;
            gen_reg   <= '0;
            start_reg <= '0;
            num_reg   <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gen_reg   <= gen_next;
            start_reg <= start_next;
            num_reg   <= num_next;
            bad_reg   <= bad_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        gen_next   = gen_reg;
        start_next = start_reg;
        num_next   = num_reg;
        bad_next   = bad_reg;
        ctl        = '0;
        idle       = 1'b0;
        fire       = 1'b0;
        case (state_reg)
            rc30_pkg::ST_IDLE:
            begin
                idle = 1'b1;
                if (accept)
                begin
                    ctl.load   = 1'b1;
                    gen_next   = '0;
                    start_next = start_row;
                    num_next   = '0;
                    bad_next   = rc30_pkg::CNT_W'(start_row) >= n;
                    state_next = rc30_pkg::ST_RUN;
                end
            end
            rc30_pkg::ST_RUN:
            begin
                if (!bad_reg && in_win && center)
                    num_next = num_reg | (rc30_pkg::NUM_W'(1) << pos);
                if (last_gen)
                    state_next = rc30_pkg::ST_DONE;
                else
                begin
                    ctl.step = 1'b1;
                    gen_next = gen_reg + rc30_pkg::ROW_W'(1);
                end
            end
            rc30_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    fire       = 1'b1;
                    state_next = rc30_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rc30_pkg::ST_IDLE;
            end
        endcase
    end

    assign number = num_reg;
    assign bad    = bad_reg;

    `RC30_ASSERT_NOW(a_gen_in_ring, state_reg == rc30_pkg::ST_RUN, gen_x < n, "generation past ring length")
    `RC30_ASSERT_NOW(a_bad_no_bits, state_reg != rc30_pkg::ST_IDLE && bad_reg, num_reg == '0, "bits set on bad start")
    `RC30_ASSERT_NEXT(a_run_ends, state_reg == rc30_pkg::ST_RUN && last_gen, state_reg == rc30_pkg::ST_DONE, "run did not end on last generation")

endmodule

`default_nettype wire

// File: hw/rtl/rule30_ca_random_number_unit.sv
// Channel | Dir  | Payload                      | Transaction
// --------+------+------------------------------+--------------------------
// req     | in   | seed[63:0] s, start_row[6:0] | valid && ready
// rsp     | out  | number[63:0], bad_start      | valid && ready
// cfg     | in   | cfg_wr_data[6:0] half_width  | cfg_wr_en at clock edge
//
// A transaction loads the cell ring, runs its generations (W = clamped half
// width; the rule 30 unit updates all cells of the ring at once) and hands
// the result off to the output register.
// The finished result sits in an output register, so a new request is taken
// while the previous result waits; the engine only holds if that register is
// still full when it finishes. Async active-low reset; half width resets to 64.
`default_nettype none
`include "rule30_ca_random_number_unit_assert.svh"

module rule30_ca_random_number_unit #(
    parameter int MAX_CELLS = rc30_pkg::MAX_CELLS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [rc30_pkg::ROW_W-1:0]  cfg_wr_data,
    rc30_req_if.sink                         req,
    rc30_rsp_if.source                       rsp
);

    // widest usable half width: half the ring, capped by the 64-bit result
    localparam int LIM_RAW = (MAX_CELLS / 2 > rc30_pkg::NUM_W) ? rc30_pkg::NUM_W : MAX_CELLS / 2;
    localparam int LIM     = (LIM_RAW < 1) ? 1 : LIM_RAW;

    logic [rc30_pkg::ROW_W-1:0]  hw_reg;
    logic [rc30_pkg::ROW_W-1:0]  w_eff;
    logic [rc30_pkg::CNT_W-1:0]  n_eff;

    rc30_pkg::ring_ctl_t         ring_ctl;
    logic                        center;
    logic                        eng_idle;
    logic                        eng_fire;
    logic [rc30_pkg::NUM_W-1:0]  eng_num;
    logic                        eng_bad;
    logic                        accept;
    logic                        out_free;

    logic                        out_valid_reg, out_valid_next;
    logic [rc30_pkg::NUM_W-1:0]  out_num_reg;
    logic                        out_bad_reg;

    // Config register: the user must write it only between transactions; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hw_reg <= rc30_pkg::HALF_WIDTH_RST;
        else if (cfg_wr_en)
            hw_reg <= cfg_wr_data;
    end

    // zero reads as one, anything above the limit as the limit
    always_comb
    begin
        if (hw_reg == '0)
            w_eff = rc30_pkg::ROW_W'(1);
        else if (hw_reg > rc30_pkg::ROW_W'(LIM))
            w_eff = rc30_pkg::ROW_W'(LIM);
        else
            w_eff = hw_reg;
    end

    assign n_eff = {w_eff, 1'b0};

    assign req.ready = eng_idle;
    assign accept    = req.valid && eng_idle;
    assign out_free  = !out_valid_reg || rsp.ready;

    rc30_ring #(
        .MAX_CELLS (MAX_CELLS)
    ) u_ring (
        .clk    (clk),
        .ctl    (ring_ctl),
        .seed   (req.seed),
        .n      (n_eff),
        .w      (w_eff),
        .center (center)
    );

    rc30_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .start_row (req.start_row),
        .w         (w_eff),
        .n         (n_eff),
        .center    (center),
        .out_free  (out_free),
        .ctl       (ring_ctl),
        .idle      (eng_idle),
        .fire      (eng_fire),
        .number    (eng_num),
        .bad       (eng_bad)
    );

    // Output register decouples the engine from the consumer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (eng_fire)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (eng_fire)
        begin
            out_num_reg <= eng_num;
            out_bad_reg <= eng_bad;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.number    = out_num_reg;
    assign rsp.bad_start = out_bad_reg;

    `RC30_ASSERT_NOW(a_fire_slot_free, eng_fire, !out_valid_reg || rsp.ready, "result overwrote a pending one")
    `RC30_ASSERT_NOW(a_upper_zero, out_valid_reg, (out_num_reg >> w_eff) == '0, "bits set above half width")
    `RC30_ASSERT_NOW(a_bad_zero, out_valid_reg && out_bad_reg, out_num_reg == '0, "bad start with non-zero number")

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

// Testbench for the rule 30 random number unit.
// A queue of pending requests feeds a clocked driver; a clocked monitor
// predicts each accepted request transaction and checks the response
// transactions in order against the predictions.
module tb;

    // Generous bound on the whole run. The slowest legal run is about
    // 450 requests, plus stalls and one long hold-off.
    localparam int LIMIT_CYCLES = 600000;
    // Long receiver hold-off used to back the unit up.
    localparam int HOLD_CYCLES  = 400;
    // Cycles allowed after the last response for stray output.
    localparam int TAIL_CYCLES  = 140;
    localparam int NUM_PHASES   = 10;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    // One request: seed pattern and the first generation to read.
    typedef struct {
        logic [rc30_pkg::SEED_W-1:0] seed;
        logic [rc30_pkg::ROW_W-1:0]  start_row;
    } draw_req_t;

    // What the unit should hand back for one request.
    typedef struct {
        logic [rc30_pkg::NUM_W-1:0] number;
        logic                       bad_start;
    } draw_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [rc30_pkg::ROW_W-1:0]    cfg_wr_data;

    rc30_req_if req_ch ();
    rc30_rsp_if rsp_ch ();

    rule30_ca_random_number_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // Requests waiting for the driver, and predictions waiting for responses.
    draw_req_t        pending_reqs[$];
    draw_t            draws_due[$];

    // Model copy of the half width register; only changes while idle.
    logic [rc30_pkg::ROW_W-1:0] half_width_model;

    int               send_idle_pct;
    int               recv_stall_pct;
    logic             req_taken;

    int               items_issued;
    int               results_seen;
    int               bad_rows_seen;
    int               widths_used;
    int               fail_count;
    int               cycle_count;

    // Hold-off handshake between stimulus and the hold counter: the
    // stimulus bumps hold_asked, the counter process answers it.
    int               hold_asked;
    int               hold_served;
    int               hold_left;

    // Phase table: register value written, idling style, random requests.
    // 0 is clamped to 1 and anything above 64 to 64 by the unit.
    int         phase_hw[NUM_PHASES]    = '{1, 0, 127, 8, 64, 3, 33, 16, 65, 2};
    idle_mode_t phase_mode[NUM_PHASES]  = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                            IDLE_SEND, IDLE_RECV, IDLE_NONE, IDLE_BOTH,
                                            IDLE_BOTH, IDLE_NONE};
    int         phase_items[NUM_PHASES] = '{35, 25, 45, 55, 45, 45, 35, 55, 25, 35};

    // ------------------------------------------------------------------
    // Predictor: loads the ring, runs 2W-1 rule 30 generations, keeps the
    // centre cell of each generation, then reads W of them from start_row
    // onwards (wrapping), most significant bit first.
    // ------------------------------------------------------------------
    function automatic draw_t rule30_draw(logic [rc30_pkg::SEED_W-1:0] seed,
                                          logic [rc30_pkg::ROW_W-1:0]  start_row,
                                          logic [rc30_pkg::ROW_W-1:0]  hw);
        int           w;
        int           n;
        int           i;
        int           g;
        logic [127:0] cells;
        logic [127:0] nxt;
        logic [127:0] centre;
        draw_t        d;
        w = (hw == 0) ? 1 : ((hw > 64) ? 64 : int'(hw));
        n = 2 * w;
        cells  = '0;
        centre = '0;
        // cells beyond bit 63 take the sign bit of the seed
        for (i = 0; i < n; i++)
            cells[i] = seed[(i < 64) ? i : 63];
        centre[0] = cells[w];
        for (g = 1; g < n; g++)
        begin
            nxt = '0;
            for (i = 0; i < n; i++)
                nxt[i] = cells[(i + n - 1) % n] ^ (cells[i] | cells[(i + 1) % n]);
            cells     = nxt;
            centre[g] = cells[w];
        end
        d.number    = '0;
        d.bad_start = (int'(start_row) >= n);
        if (!d.bad_start)
        begin
            for (i = 0; i < w; i++)
                d.number[w - 1 - i] = centre[(int'(start_row) + i) % n];
        end
        return d;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s differs: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Clock and cycle bound
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Run stopped at the cycle bound with %0d responses outstanding",
                     items_issued - results_seen);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request driver: changes on the falling edge. A request on the bus
    // stays put until the monitor saw it taken at the rising edge.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : req_driver
        draw_req_t item;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (req_ch.valid && !req_taken)
            ; // still waiting for the unit to take it
        else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            item = pending_reqs.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.seed      <= item.seed;
            req_ch.start_row <= item.start_row;
        end
        else
            req_ch.valid <= 1'b0;
    end

    // Long hold-off counter, kept apart from the random stalls.
    always @(negedge clk)
    begin
        if (hold_served != hold_asked)
        begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_asked;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Response side ready: random stalls plus the hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels on the rising edge. An accepted
    // request is predicted at once with the current half width; an
    // accepted response is checked against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        draw_t want;
        draw_t got;
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            req_taken <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                want = rule30_draw(req_ch.seed, req_ch.start_row, half_width_model);
                if (want.bad_start)
                    bad_rows_seen++;
                draws_due.push_back(want);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                got.number    = rsp_ch.number;
                got.bad_start = rsp_ch.bad_start;
                if (draws_due.size() == 0)
                    report_mismatch("unrequested response number", got.number, '0);
                else
                begin
                    want = draws_due.pop_front();
                    if (got.number !== want.number)
                        report_mismatch("number", got.number, want.number);
                    if (got.bad_start !== want.bad_start)
                        report_mismatch("bad_start", 64'(got.bad_start),
                                        64'(want.bad_start));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_draw(logic [rc30_pkg::SEED_W-1:0] seed,
                              logic [rc30_pkg::ROW_W-1:0] start_row);
        draw_req_t item;
        item.seed      = seed;
        item.start_row = start_row;
        pending_reqs.push_back(item);
        items_issued++;
    endtask

    // Every request gives exactly one response, so the counts meeting means
    // the unit is empty.
    task automatic wait_for_all_draws();
        do
            @(negedge clk);
        while (results_seen != items_issued);
    endtask

    task automatic write_half_width(logic [rc30_pkg::ROW_W-1:0] value);
        repeat (4) @(negedge clk);
        cfg_wr_en        <= 1'b1;
        cfg_wr_data      <= value;
        half_width_model = value;
        widths_used++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default:   begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
    endtask

    function automatic logic [rc30_pkg::SEED_W-1:0] pick_seed();
        logic [rc30_pkg::SEED_W-1:0] s;
        case ($urandom_range(19))
            0:       s = '0;
            1:       s = '1;
            2:       s = 64'h8000_0000_0000_0000;
            3:       s = 64'h7FFF_FFFF_FFFF_FFFF;
            default: s = {$urandom, $urandom};
        endcase
        return s;
    endfunction

    // Mostly legal start rows for the current width, some over the whole field.
    function automatic logic [rc30_pkg::ROW_W-1:0] pick_start(int w);
        int top;
        top = (2 * w - 1 > 127) ? 127 : 2 * w - 1;
        if ($urandom_range(4) == 0)
            return rc30_pkg::ROW_W'($urandom_range(127));
        return rc30_pkg::ROW_W'($urandom_range(top));
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int p;
        int k;
        int w;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        req_ch.valid     = 1'b0;
        req_ch.seed      = '0;
        req_ch.start_row = '0;
        rsp_ch.ready     = 1'b0;
        half_width_model = rc30_pkg::HALF_WIDTH_RST;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        items_issued     = 0;
        results_seen     = 0;
        bad_rows_seen    = 0;
        widths_used      = 1;
        fail_count       = 0;
        cycle_count      = 0;
        hold_asked       = 0;
        hold_served      = 0;
        hold_left        = 0;
        req_taken        = 1'b0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed transactions at the reset width of 64: zero seed, all
        // ones, sign bit alone, largest positive, sparse and striped rows,
        // and the first and last start rows.
        set_idling(IDLE_NONE);
        @(posedge clk);
        queue_draw(64'h0, 7'd0);
        queue_draw(64'h0, 7'd127);
        queue_draw('1, 7'd0);
        queue_draw('1, 7'd127);
        queue_draw(64'h8000_0000_0000_0000, 7'd0);
        queue_draw(64'h8000_0000_0000_0000, 7'd64);
        queue_draw(64'h7FFF_FFFF_FFFF_FFFF, 7'd63);
        queue_draw(64'h7FFF_FFFF_FFFF_FFFF, 7'd127);
        queue_draw(64'h1, 7'd0);
        queue_draw(64'h1, 7'd1);
        queue_draw(64'h0000_0001_0000_0000, 7'd64);
        queue_draw(64'hAAAA_AAAA_AAAA_AAAA, 7'd32);
        queue_draw(64'h5555_5555_5555_5555, 7'd96);
        queue_draw(64'h0123_4567_89AB_CDEF, 7'd65);
        queue_draw(64'hFEDC_BA98_7654_3210, 7'd126);
        wait_for_all_draws();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_half_width(rc30_pkg::ROW_W'(phase_hw[p]));
            w = (phase_hw[p] == 0) ? 1 : ((phase_hw[p] > 64) ? 64 : phase_hw[p]);
            set_idling(phase_mode[p]);
            @(posedge clk);

            // Edges of the start row for this width, bad start included
            // wherever the field can reach it.
            queue_draw(pick_seed(), rc30_pkg::ROW_W'(2 * w - 1));
            queue_draw(64'h0, 7'd0);
            if (2 * w <= 127)
            begin
                queue_draw(pick_seed(), rc30_pkg::ROW_W'(2 * w));
                queue_draw(pick_seed(), 7'd127);
            end

            // Back-pressure: hold the response side for a long stretch while
            // requests keep coming, so the output register fills and the
            // unit stops taking requests.
            if (p == 6)
            begin
                wait_for_all_draws();
                @(posedge clk);
                hold_asked++;
                for (k = 0; k < 8; k++)
                    queue_draw(pick_seed(), pick_start(w));
                wait_for_all_draws();
                @(posedge clk);
            end

            for (k = 0; k < phase_items[p]; k++)
            begin
                // once, let the unit drain fully mid-phase before going on
                if (p == 4 && k == phase_items[p] / 2)
                begin
                    wait_for_all_draws();
                    @(posedge clk);
                end
                queue_draw(pick_seed(), pick_start(w));
            end
            wait_for_all_draws();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (draws_due.size() != 0)
            report_mismatch("outstanding predictions", 64'(draws_due.size()), '0);

        $display("Covered %0d requests across %0d half width settings (0, 1..64, >64)",
                 items_issued, widths_used);
        $display("%0d bad start rows, idling and stalls on both sides, one long hold-off",
                 bad_rows_seen);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rc30_pkg.sv
hw/rtl/rc30_if.sv
hw/rtl/rc30_ring.sv
hw/rtl/rc30_ctrl.sv
hw/rtl/rule30_ca_random_number_unit.sv
verif/tb.sv
